// ===== rtl/smpq_pkg.sv =====
// Shared types and codes for the stable minimum priority queue.
// Command and status bundles passed between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

   // operation codes of the func field
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic accept;     // capture the request transaction and its flags
      logic pop;        // advance head pointer, decrement count
      logic rd_prev;    // read entry just below the insertion cursor
      logic shift;      // move the entry read up by one slot, step cursor down
      logic place;      // write the new entry at the cursor, increment count
      logic rd_head;    // read the entry at the head pointer
      logic load_head;  // refresh the head register from read data
      logic load_rsp;   // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic cursor_zero;
      logic greater;    // entry read has a strictly larger priority
      logic rsp_free;   // result register can take a new transaction
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/smpq_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing; widths come from interface parameters.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_req_if #(
   parameter int PRIO_W = 16,
   parameter int PAY_W  = 16
);
   logic              valid;
   logic              ready;
   logic              func;
   logic [PRIO_W-1:0] new_priority;
   logic [PAY_W-1:0]  new_payload;

   modport source (output valid, output func, output new_priority, output new_payload,
                   input ready);
   modport sink   (input valid, input func, input new_priority, input new_payload,
                   output ready);
endinterface

interface smpq_rsp_if #(
   parameter int PRIO_W = 16,
   parameter int PAY_W  = 16,
   parameter int CNT_W  = 5
);
   logic              valid;
   logic              ready;
   logic              popped_valid;
   logic [PAY_W-1:0]  popped_payload;
   logic              overflow;
   logic              head_valid;
   logic [PRIO_W-1:0] head_priority;
   logic [PAY_W-1:0]  head_payload;
   logic [CNT_W-1:0]  entry_count;

   modport source (output valid, output popped_valid, output popped_payload,
                   output overflow, output head_valid, output head_priority,
                   output head_payload, output entry_count, input ready);
   modport sink   (input valid, input popped_valid, input popped_payload,
                   input overflow, input head_valid, input head_priority,
                   input head_payload, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/smpq_ctrl.sv =====
// Controller state machine for the priority queue.
// Depends on smpq_pkg for command, status and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_func,
   output logic                     req_ready,
   input  wire smpq_pkg::status_type status,
   output smpq_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_HEAD_RD,
      ST_HEAD_LD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      accept;

   assign accept    = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (req_func == smpq_pkg::FUNC_DEQUEUE) begin
                  if (status.empty) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ST_HEAD_RD;
                  end
               end else begin
                  state_in = status.full ? ST_FINISH : ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.cursor_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.greater) begin
               cmd.shift = 1'b1;
               state_in  = ST_CHECK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_HEAD_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_HEAD_LD;
         end
         ST_HEAD_LD: begin
            cmd.load_head = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/smpq_dpath.sv =====
// Datapath: circular entry memory, head/count/cursor registers, result register.
// Depends on smpq_pkg for command and status bundles.
`timescale 1ns / 1ps
`default_nettype none

module smpq_dpath #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 16,
   parameter int CNT_W         = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire smpq_pkg::cmd_type        cmd,
   output smpq_pkg::status_type          status,
   input  wire logic                     req_func,
   input  wire logic [PRIORITY_BITS-1:0] req_priority,
   input  wire logic [PAYLOAD_BITS-1:0]  req_payload,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_popped_valid,
   output logic [PAYLOAD_BITS-1:0]       rsp_popped_payload,
   output logic                          rsp_overflow,
   output logic                          rsp_head_valid,
   output logic [PRIORITY_BITS-1:0]      rsp_head_priority,
   output logic [PAYLOAD_BITS-1:0]       rsp_head_payload,
   output logic [CNT_W-1:0]              rsp_entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SW = CNT_W + 1;
   localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;

   // entry storage, priority in the upper bits
   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_data_ff;

   logic [CNT_W-1:0]         count_ff;
   logic [AW-1:0]            head_ptr_ff;
   logic [CNT_W-1:0]         cursor_ff;
   logic [EW-1:0]            head_ff;
   logic [PRIORITY_BITS-1:0] new_prio_ff;
   logic [PAYLOAD_BITS-1:0]  new_pay_ff;
   logic                     pop_flag_ff;
   logic                     ovf_flag_ff;
   logic [PAYLOAD_BITS-1:0]  pop_pay_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_popped_valid_ff;
   logic [PAYLOAD_BITS-1:0]  rsp_popped_payload_ff;
   logic                     rsp_overflow_ff;
   logic                     rsp_head_valid_ff;
   logic [PRIORITY_BITS-1:0] rsp_head_priority_ff;
   logic [PAYLOAD_BITS-1:0]  rsp_head_payload_ff;
   logic [CNT_W-1:0]         rsp_entry_count_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          mem_we;
   logic [AW-1:0] head_next;
   logic          full;
   logic          empty;
   logic          is_dequeue;

   // map a logical offset from the head onto a memory slot
   function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] ofs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(ofs);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign is_dequeue = (req_func == smpq_pkg::FUNC_DEQUEUE);

   assign status.full        = full;
   assign status.empty       = empty;
   assign status.cursor_zero = (cursor_ff == '0);
   assign status.greater     = (rd_data_ff[EW-1:PAYLOAD_BITS] > new_prio_ff);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   // memory addressing
   assign rd_addr   = cmd.rd_prev ? to_phys(head_ptr_ff, cursor_ff - CNT_W'(1)) : head_ptr_ff;
   assign wr_addr   = to_phys(head_ptr_ff, cursor_ff);
   assign mem_we    = cmd.shift || cmd.place;
   assign wr_data   = cmd.shift ? rd_data_ff : {new_prio_ff, new_pay_ff};
   assign head_next = (head_ptr_ff == AW'(CAPACITY - 1)) ? '0 : head_ptr_ff + AW'(1);

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_prev || cmd.rd_head) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers: count, head pointer, cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_ptr_ff <= '0;
         cursor_ff   <= '0;
      end else begin
         if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.pop) begin
            head_ptr_ff <= head_next;
         end
         if (cmd.accept) begin
            cursor_ff <= count_ff;
         end else if (cmd.shift) begin
            cursor_ff <= cursor_ff - CNT_W'(1);
         end
      end
   end

   // capture the transaction and keep a copy of the head entry
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_prio_ff <= req_priority;
         new_pay_ff  <= req_payload;
         pop_flag_ff <= is_dequeue && !empty;
         ovf_flag_ff <= !is_dequeue && full;
         pop_pay_ff  <= (is_dequeue && !empty) ? head_ff[PAYLOAD_BITS-1:0] : '0;
      end
      if (cmd.place && (cursor_ff == '0)) begin
         head_ff <= {new_prio_ff, new_pay_ff};
      end else if (cmd.load_head) begin
         head_ff <= rd_data_ff;
      end
   end

   // result register: load when free, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_popped_valid_ff   <= pop_flag_ff;
         rsp_popped_payload_ff <= pop_pay_ff;
         rsp_overflow_ff       <= ovf_flag_ff;
         rsp_head_valid_ff     <= !empty;
         rsp_head_priority_ff  <= empty ? '0 : head_ff[EW-1:PAYLOAD_BITS];
         rsp_head_payload_ff   <= empty ? '0 : head_ff[PAYLOAD_BITS-1:0];
         rsp_entry_count_ff    <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_popped_valid   = rsp_popped_valid_ff;
   assign rsp_popped_payload = rsp_popped_payload_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_head_valid     = rsp_head_valid_ff;
   assign rsp_head_priority  = rsp_head_priority_ff;
   assign rsp_head_payload   = rsp_head_payload_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;

endmodule

`default_nettype wire

// ===== rtl/stable_min_priority_queue_core.sv =====
// An enqueue walks down through the entries it moves; a dequeue reads and loads the new head;
// a dropped enqueue or an empty dequeue goes straight to the result.
// One transaction is handled at a time; the insertion walk (one memory read, then one
// compare-and-move, per entry moved) sets the insert time. The next request can be taken in
// the cycle after the result is loaded, even while that result still waits.
// Reset (synchronous) empties the queue at once; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue_core #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   smpq_req_if.sink   req_ch,
   smpq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   smpq_pkg::cmd_type    cmd;
   smpq_pkg::status_type status;

   // sequencing
   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and result register
   smpq_dpath #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .CNT_W         (CNT_W)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_ch.func),
      .req_priority       (req_ch.new_priority),
      .req_payload        (req_ch.new_payload),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_popped_valid   (rsp_ch.popped_valid),
      .rsp_popped_payload (rsp_ch.popped_payload),
      .rsp_overflow       (rsp_ch.overflow),
      .rsp_head_valid     (rsp_ch.head_valid),
      .rsp_head_priority  (rsp_ch.head_priority),
      .rsp_head_payload   (rsp_ch.head_payload),
      .rsp_entry_count    (rsp_ch.entry_count)
   );

endmodule

`default_nettype wire

// ===== rtl/smpq_checker.sv =====
// Port-level checks on the response channel of the priority queue core.
// Bound to stable_min_priority_queue_core; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module smpq_checker #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 16,
   parameter int CNT_W         = 5
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_popped_valid,
   input wire logic [PAYLOAD_BITS-1:0]  rsp_popped_payload,
   input wire logic                     rsp_overflow,
   input wire logic                     rsp_head_valid,
   input wire logic [PRIORITY_BITS-1:0] rsp_head_priority,
   input wire logic [PAYLOAD_BITS-1:0]  rsp_head_payload,
   input wire logic [CNT_W-1:0]         rsp_entry_count
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // head flag tracks the count
   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_entry_count != '0)))
      else $error("head_valid disagrees with entry_count");

   // empty queue shows a zero head
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> (rsp_head_priority == '0) && (rsp_head_payload == '0))
      else $error("empty queue shows a nonzero head");

   // a dropped insert only happens on a full queue and never with a removal
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         !rsp_popped_valid && (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("overflow without a full queue");

   // no removal, no popped payload
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_popped_valid |-> (rsp_popped_payload == '0))
      else $error("popped payload without a removal");

endmodule

bind stable_min_priority_queue_core smpq_checker #(
   .CAPACITY      (CAPACITY),
   .PRIORITY_BITS (PRIORITY_BITS),
   .PAYLOAD_BITS  (PAYLOAD_BITS),
   .CNT_W         ($clog2(CAPACITY + 1))
) u_smpq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_popped_valid   (rsp_ch.popped_valid),
   .rsp_popped_payload (rsp_ch.popped_payload),
   .rsp_overflow       (rsp_ch.overflow),
   .rsp_head_valid     (rsp_ch.head_valid),
   .rsp_head_priority  (rsp_ch.head_priority),
   .rsp_head_payload   (rsp_ch.head_payload),
   .rsp_entry_count    (rsp_ch.entry_count)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for stable_min_priority_queue_core.
// Depends on smpq_pkg and the smpq_req_if / smpq_rsp_if channel interfaces.
// An in-bench sorted-slot model predicts every response; every response is checked against it.
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY     = 16;
   localparam int PRIO_W       = 16;
   localparam int PAY_W        = 16;
   localparam int CNT_W        = 5;
   // worst-case insert walk plus margin
   localparam int TAIL_CYCLES  = 4 + 2 * CAPACITY + 8;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic              popped_valid;
      logic [PAY_W-1:0]  popped_payload;
      logic              overflow;
      logic              head_valid;
      logic [PRIO_W-1:0] head_priority;
      logic [PAY_W-1:0]  head_payload;
      logic [CNT_W-1:0]  entry_count;
   } queue_status_type;

   logic clock;
   logic reset;

   smpq_req_if #(.PRIO_W(PRIO_W), .PAY_W(PAY_W)) req_ch ();
   smpq_rsp_if #(.PRIO_W(PRIO_W), .PAY_W(PAY_W), .CNT_W(CNT_W)) rsp_ch ();

   stable_min_priority_queue_core #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIO_W),
      .PAYLOAD_BITS  (PAY_W)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow copy of the sorted slots
   logic [PRIO_W-1:0] shadow_prio [CAPACITY];
   logic [PAY_W-1:0]  shadow_pay  [CAPACITY];
   int unsigned       shadow_count = 0;

   queue_status_type pending_status[$];
   int unsigned      mismatch_count = 0;
   int unsigned      idle_cycles = 0;
   bit               idle_gaps = 1'b1;
   int unsigned      rsp_hold_request = 0;

   // Apply one operation to the shadow queue and return the response it should give.
   function automatic queue_status_type predict_queue_op(logic op, logic [PRIO_W-1:0] prio,
                                                         logic [PAY_W-1:0] pay);
      queue_status_type st;
      int unsigned      pos;
      st = '0;
      if (op == smpq_pkg::FUNC_ENQUEUE) begin
         if (shadow_count >= CAPACITY) begin
            st.overflow = 1'b1;
         end else begin
            // insert after every entry of lower or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
            for (int unsigned i = shadow_count; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_pay[i]  = shadow_pay[i-1];
            end
            shadow_prio[pos] = prio;
            shadow_pay[pos]  = pay;
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         st.popped_valid   = 1'b1;
         st.popped_payload = shadow_pay[0];
         for (int unsigned i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1] = shadow_prio[i];
            shadow_pay[i-1]  = shadow_pay[i];
         end
         shadow_count--;
      end
      if (shadow_count > 0) begin
         st.head_valid    = 1'b1;
         st.head_priority = shadow_prio[0];
         st.head_payload  = shadow_pay[0];
      end
      st.entry_count = CNT_W'(shadow_count);
      return st;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_gaps) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Favor a narrow band so ties are common, with extremes and full-range values mixed in.
   function automatic logic [PRIO_W-1:0] pick_priority();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return PRIO_W'($urandom_range(0, 7));
      if (roll < 55) return '0;
      if (roll < 65) return '1;
      return PRIO_W'($urandom());
   endfunction

   // Offer one transaction and wait for it to be taken; call at a rising edge.
   task automatic send_op(input logic op, input logic [PRIO_W-1:0] prio,
                          input logic [PAY_W-1:0] pay);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= op;
      req_ch.new_priority <= prio;
      req_ch.new_payload  <= pay;
      do @(posedge clock); while (!req_ch.ready);
      pending_status.push_back(predict_queue_op(op, prio, pay));
   endtask

   // Stop offering and wait until every predicted response has been checked.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_dequeue();
      send_op(smpq_pkg::FUNC_DEQUEUE, '1, '1);
      send_op(smpq_pkg::FUNC_DEQUEUE, '0, '0);
   endtask

   // Extreme values, equal priorities leaving in arrival order, head replacement.
   task automatic test_extremes_and_ties();
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'hFFFF, 16'h0000);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h0000, 16'hFFFF);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h8000, 16'h5555);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h8000, 16'hAAAA);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h8000, 16'h1234);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h0000, 16'h00FF);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'hFFFF, 16'hFF00);
      repeat (4) send_op(smpq_pkg::FUNC_DEQUEUE, PRIO_W'($urandom()), PAY_W'($urandom()));
   endtask

   // Fill to capacity with no idling, overflow it, then drain past empty.
   task automatic test_full_and_overflow();
      idle_gaps = 1'b0;
      while (shadow_count < CAPACITY) begin
         send_op(smpq_pkg::FUNC_ENQUEUE, pick_priority(), PAY_W'($urandom()));
      end
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'h0000, 16'hBEEF);
      send_op(smpq_pkg::FUNC_ENQUEUE, 16'hFFFF, 16'hFFFF);
      while (shadow_count > 0) send_op(smpq_pkg::FUNC_DEQUEUE, '0, '0);
      send_op(smpq_pkg::FUNC_DEQUEUE, '1, '1);
      idle_gaps = 1'b1;
   endtask

   // Hold the response side off while requests keep coming, then let it all drain.
   task automatic test_backpressure();
      idle_gaps = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      repeat (24) begin
         if ($urandom_range(99) < 70)
            send_op(smpq_pkg::FUNC_ENQUEUE, pick_priority(), PAY_W'($urandom()));
         else
            send_op(smpq_pkg::FUNC_DEQUEUE, PRIO_W'($urandom()), PAY_W'($urandom()));
      end
      idle_gaps = 1'b1;
      hold_until_drained();
   endtask

   // Segments with different enqueue bias sweep the fill level between empty and full.
   task automatic test_random_mix();
      int unsigned sent;
      int unsigned seg_len;
      int unsigned enq_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(2))
            0: enq_pct = 80;
            1: enq_pct = 50;
            default: enq_pct = 25;
         endcase
         idle_gaps = ($urandom_range(3) != 0);
         repeat (seg_len) begin
            if ($urandom_range(99) < enq_pct)
               send_op(smpq_pkg::FUNC_ENQUEUE, pick_priority(), PAY_W'($urandom()));
            else
               send_op(smpq_pkg::FUNC_DEQUEUE, PRIO_W'($urandom()), PAY_W'($urandom()));
            sent++;
         end
      end
      idle_gaps = 1'b1;
   endtask

   // Drive response ready: random stalls, or a long hold when one is requested.
   initial begin : rsp_ready_driver
      int unsigned stall;
      int unsigned hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ch.ready <= 1'b0;
            while (hold > 0) begin
               @(posedge clock);
               hold--;
            end
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what, input queue_status_type want,
                                  input queue_status_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected pv=%b pp=%h ov=%b hv=%b hp=%h hd=%h cnt=%0d",
                  $realtime, what,
                  want.popped_valid, want.popped_payload, want.overflow, want.head_valid,
                  want.head_priority, want.head_payload, want.entry_count);
         $display("%0t: %s: got      pv=%b pp=%h ov=%b hv=%b hp=%h hd=%h cnt=%0d",
                  $realtime, what,
                  got.popped_valid, got.popped_payload, got.overflow, got.head_valid,
                  got.head_priority, got.head_payload, got.entry_count);
      end
   endtask

   // Compare each response transaction with the oldest prediction.
   always @(posedge clock) begin : rsp_checker
      queue_status_type got;
      queue_status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{popped_valid:   rsp_ch.popped_valid,
                 popped_payload: rsp_ch.popped_payload,
                 overflow:       rsp_ch.overflow,
                 head_valid:     rsp_ch.head_valid,
                 head_priority:  rsp_ch.head_priority,
                 head_payload:   rsp_ch.head_payload,
                 entry_count:    rsp_ch.entry_count};
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected response", '0, got);
         end else begin
            want = pending_status.pop_front();
            if (got !== want) report_mismatch("response mismatch", want, got);
         end
      end
   end

   // Count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : main_sequence
      req_ch.valid        <= 1'b0;
      req_ch.func         <= smpq_pkg::FUNC_ENQUEUE;
      req_ch.new_priority <= '0;
      req_ch.new_payload  <= '0;
      reset               <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_dequeue();
      test_extremes_and_ties();
      test_full_and_overflow();
      test_backpressure();
      test_random_mix();

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/smpq_pkg.sv
rtl/smpq_if.sv
rtl/smpq_ctrl.sv
rtl/smpq_dpath.sv
rtl/stable_min_priority_queue_core.sv
rtl/smpq_checker.sv
tb/sv/tb_top.sv
